FILE: hw/rtl/rplb_pkg.sv
// shared types, constants and helpers for the random probe load balancer
package rplb_pkg;

  localparam int NUM_BINS_DEF = 8;
  localparam int LOAD_W = 32;
  localparam int EPS_W = 16;
  localparam int BIN_W = 3;
  localparam int ACT_W = 2;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1507;

  typedef logic [LOAD_W-1:0] load_t;

  // action codes reported with each result
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_DIVIDE = 2'd1,
    ACT_MERGE  = 2'd2,
    ACT_SAME   = 2'd3
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_MUL_B,
    S_MUL_A,
    S_DECIDE,
    S_SW_RD,
    S_SW_WR,
    S_DONE
  } state_t;

  // what one slot of the rebuilt row takes
  typedef enum logic [1:0] {
    K_OLD,
    K_HI,
    K_LO,
    K_NB
  } slot_kind_t;

  // unsigned add that sticks at the top of the load range
  function automatic load_t sat_add(load_t a, load_t b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? '1 : s[LOAD_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/rplb_if.sv
// handshake channels: input items, results and the eps configuration write
interface rplb_item_if;
  logic                       valid;
  logic                       ready;
  logic [rplb_pkg::BIN_W-1:0] target_bin;
  logic [rplb_pkg::BIN_W-1:0] probe_bin;
  modport source (output valid, target_bin, probe_bin, input ready);
  modport sink (input valid, target_bin, probe_bin, output ready);
endinterface

interface rplb_result_if;
  logic                        valid;
  logic                        ready;
  logic [rplb_pkg::LOAD_W-1:0] step_moves;
  logic [rplb_pkg::LOAD_W-1:0] step_cost;
  logic [rplb_pkg::ACT_W-1:0]  action;
  modport source (output valid, step_moves, step_cost, action, input ready);
  modport sink (input valid, step_moves, step_cost, action, output ready);
endinterface

interface rplb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rplb_pkg::EPS_W-1:0] eps_q16;
  modport source (output valid, eps_q16, input ready);
  modport sink (input valid, eps_q16, output ready);
endinterface

FILE: hw/rtl/rplb_ram.sv
// generic single write port RAM with registered read
module rplb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/random_probe_load_balancer_top.sv
// random probe load balancer: bin loads in a two-bank RAM, shared multiplier, copy sweep
// Order of states: S_INC then S_DONE when probe equals target; S_INC, S_MUL_B, S_MUL_A,
// S_DECIDE, S_DONE when the pair is balanced; a rebuild adds S_SW_RD, S_SW_WR per bin.
// One item at a time: the imbalance test runs two passes through one 16x32
// multiplier, and a rebuild copies each bin through the RAM read port to the other bank.
// Reset (synchronous): per-bin valid flags make every load read as zero, eps_q16
// returns to 1507, no clearing pass is needed.
module random_probe_load_balancer_top #(
  parameter int NUM_BINS = rplb_pkg::NUM_BINS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rplb_cfg_if.sink       cfg,
  rplb_item_if.sink      items,
  rplb_result_if.source  results
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int ADDR_W = IDX_W + 1;
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
  localparam int LW = rplb_pkg::LOAD_W;
  localparam int EW = rplb_pkg::EPS_W;
  localparam int BW = rplb_pkg::BIN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_BINS - 2);

  typedef logic [IDX_W-1:0] idx_t;

  rplb_pkg::state_t     state, state_next;
  rplb_pkg::slot_kind_t kind, kind_next;
  rplb_pkg::action_t    act;
  rplb_pkg::action_t    out_action;

  logic                  cur;
  logic [1:0][NUM_BINS-1:0] vld;
  idx_t                  t_idx, p_idx, nb_idx, w, slot, rm_lo, rm_hi, src_next;
  logic [EW-1:0]         eps;
  rplb_pkg::load_t       la, lb, ln, hi, lo, moves, nbnew;
  logic [LW+EW-1:0]      prod;
  logic                  unbal_a, div_mode, rd_ok;
  logic                  out_valid;
  rplb_pkg::load_t       out_moves, out_cost;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  rplb_pkg::load_t       ram_wdata, ram_rdata, rd_load, la_inc, sweep_data, mul_b;
  logic [BW-1:0]         t_red, p_red;

  // decide-step values
  logic                  unbal, div_next;
  logic [LW:0]           sum_ab, la_p1;
  logic [LW+1:0]         sum_p1;
  rplb_pkg::load_t       diff_ab, lo_m;
  idx_t                  pos_div, ti_merge;

  // sweep source mapping
  logic [IDX_W:0]        r_ext, s1, s2;

  rplb_ram #(
    .WIDTH (LW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // reduce incoming bin numbers modulo NUM_BINS
  always_comb begin
    t_red = items.target_bin;
    p_red = items.probe_bin;
    for (int i = 0; i < 2; i++) begin
      if (int'(t_red) >= NUM_BINS) begin
        t_red = t_red - BW'(NUM_BINS);
      end
      if (int'(p_red) >= NUM_BINS) begin
        p_red = p_red - BW'(NUM_BINS);
      end
    end
  end

  // unwritten entries read as zero
  assign rd_load = rd_ok ? ram_rdata : '0;
  assign la_inc = rplb_pkg::sat_add(rd_load, rplb_pkg::load_t'(1));
  assign nb_idx = (p_idx == LAST_IDX) ? '0 : p_idx + idx_t'(1);
  assign mul_b = (state == rplb_pkg::S_MUL_B) ? rd_load : la;

  // imbalance test and rebalance arithmetic
  always_comb begin
    unbal = unbal_a || ({lb, {EW{1'b0}}} <= prod);
    div_next = (ln > la) || (({1'b0, p_idx} + (IDX_W+1)'(1)) == {1'b0, t_idx});
    sum_ab = {1'b0, la} + {1'b0, lb};
    sum_p1 = {1'b0, sum_ab} + (LW+2)'(1);
    la_p1 = {1'b0, la} + (LW+1)'(1);
    diff_ab = (la > lb) ? la - lb : lb - la;
    lo_m = {1'b0, la[LW-1:1]};
    pos_div = (t_idx > LAST_POS) ? LAST_POS : t_idx;
    ti_merge = (p_idx < t_idx) ? t_idx - idx_t'(1) : t_idx;
  end

  // source slot of the rebuilt row for sweep position w
  always_comb begin
    r_ext = {1'b0, w};
    kind_next = rplb_pkg::K_OLD;
    if (w < slot) begin
      r_ext = {1'b0, w};
    end else if (w == slot) begin
      kind_next = rplb_pkg::K_HI;
    end else if ({1'b0, w} == ({1'b0, slot} + (IDX_W+1)'(1))) begin
      kind_next = rplb_pkg::K_LO;
    end else begin
      r_ext = {1'b0, w} - (div_mode ? (IDX_W+1)'(2) : (IDX_W+1)'(1));
    end
    s1 = r_ext + (IDX_W+1)'(r_ext >= {1'b0, rm_lo});
    s2 = s1 + (IDX_W+1)'(div_mode && (s1 >= {1'b0, rm_hi}));
    src_next = s2[IDX_W-1:0];
    if (kind_next == rplb_pkg::K_OLD && !div_mode && src_next == nb_idx) begin
      kind_next = rplb_pkg::K_NB;
    end
  end

  // rebuilt slot value
  always_comb begin
    unique case (kind)
      rplb_pkg::K_HI:  sweep_data = hi;
      rplb_pkg::K_LO:  sweep_data = lo;
      rplb_pkg::K_NB:  sweep_data = nbnew;
      rplb_pkg::K_OLD: sweep_data = rd_load;
      default:         sweep_data = rd_load;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rplb_pkg::S_IDLE: begin
        if (items.valid) state_next = rplb_pkg::S_INC;
      end
      rplb_pkg::S_INC: begin
        state_next = (p_idx == t_idx) ? rplb_pkg::S_DONE : rplb_pkg::S_MUL_B;
      end
      rplb_pkg::S_MUL_B:  state_next = rplb_pkg::S_MUL_A;
      rplb_pkg::S_MUL_A:  state_next = rplb_pkg::S_DECIDE;
      rplb_pkg::S_DECIDE: state_next = unbal ? rplb_pkg::S_SW_RD : rplb_pkg::S_DONE;
      rplb_pkg::S_SW_RD:  state_next = rplb_pkg::S_SW_WR;
      rplb_pkg::S_SW_WR: begin
        state_next = (w == LAST_IDX) ? rplb_pkg::S_DONE : rplb_pkg::S_SW_RD;
      end
      rplb_pkg::S_DONE: begin
        if (!out_valid || results.ready) state_next = rplb_pkg::S_IDLE;
      end
      default: state_next = rplb_pkg::S_IDLE;
    endcase
  end

  // RAM ports and handshake outputs
  always_comb begin
    items.ready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = {cur, t_idx};
    ram_wdata = la_inc;
    ram_raddr = {cur, t_idx};
    unique case (state)
      rplb_pkg::S_IDLE: begin
        items.ready = 1'b1;
        ram_raddr = {cur, IDX_W'(t_red)};
      end
      rplb_pkg::S_INC: begin
        ram_we = 1'b1;
        ram_raddr = {cur, p_idx};
      end
      rplb_pkg::S_MUL_B: ram_raddr = {cur, nb_idx};
      rplb_pkg::S_SW_RD: ram_raddr = {cur, src_next};
      rplb_pkg::S_SW_WR: begin
        ram_we = 1'b1;
        ram_waddr = {~cur, w};
        ram_wdata = sweep_data;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rplb_pkg::S_IDLE;
      cur <= 1'b0;
      vld <= '0;
      eps <= rplb_pkg::EPS_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        eps <= cfg.eps_q16;
      end
      if (state == rplb_pkg::S_INC) begin
        vld[cur][t_idx] <= 1'b1;
      end
      if (state == rplb_pkg::S_SW_WR) begin
        vld[~cur][w] <= 1'b1;
        if (w == LAST_IDX) cur <= ~cur;
      end
      if (state == rplb_pkg::S_DONE && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ok <= vld[ram_raddr[IDX_W]][ram_raddr[IDX_W-1:0]];
    prod <= {{LW{1'b0}}, eps} * {{EW{1'b0}}, mul_b};
    unique case (state)
      rplb_pkg::S_IDLE: begin
        t_idx <= IDX_W'(t_red);
        p_idx <= IDX_W'(p_red);
      end
      rplb_pkg::S_INC: begin
        la <= la_inc;
        moves <= '0;
        act <= (p_idx == t_idx) ? rplb_pkg::ACT_SAME : rplb_pkg::ACT_NONE;
      end
      rplb_pkg::S_MUL_B: lb <= rd_load;
      rplb_pkg::S_MUL_A: begin
        ln <= rd_load;
        unbal_a <= ({la, {EW{1'b0}}} <= prod);
      end
      rplb_pkg::S_DECIDE: begin
        w <= '0;
        div_mode <= div_next;
        nbnew <= rplb_pkg::sat_add(ln, lb);
        if (unbal) begin
          if (div_next) begin
            act <= rplb_pkg::ACT_DIVIDE;
            hi <= sum_p1[LW:1];
            lo <= sum_ab[LW:1];
            moves <= {1'b0, diff_ab[LW-1:1]};
            slot <= pos_div;
            rm_lo <= (t_idx < p_idx) ? t_idx : p_idx;
            rm_hi <= (t_idx < p_idx) ? p_idx : t_idx;
          end else begin
            act <= rplb_pkg::ACT_MERGE;
            hi <= la_p1[LW:1];
            lo <= lo_m;
            moves <= rplb_pkg::sat_add(lb, lo_m);
            slot <= ti_merge;
            rm_lo <= p_idx;
            rm_hi <= p_idx;
          end
        end
      end
      rplb_pkg::S_SW_RD: kind <= kind_next;
      rplb_pkg::S_SW_WR: w <= w + idx_t'(1);
      rplb_pkg::S_DONE: begin
        if (!out_valid || results.ready) begin
          out_moves <= moves;
          out_cost <= rplb_pkg::sat_add(moves, rplb_pkg::load_t'(1));
          out_action <= act;
        end
      end
      default: ;
    endcase
  end

  assign cfg.ready = 1'b1;
  assign results.valid = out_valid;
  assign results.step_moves = out_moves;
  assign results.step_cost = out_cost;
  assign results.action = out_action;

  // checks
  a_same_cost: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.action == rplb_pkg::ACT_SAME
      |-> results.step_moves == '0 && results.step_cost == 32'd1)
    else $error("probe-equals-target result carries moves");

  a_cost: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.step_cost == results.step_moves + 32'd1) ||
      (results.step_moves == '1 && results.step_cost == '1))
    else $error("step cost does not follow step moves");

  a_sweep_bank: assert property (@(posedge clk) disable iff (rst)
    ram_we && state == rplb_pkg::S_SW_WR |-> ram_waddr[IDX_W] != cur)
    else $error("rebuild writes into the live bank");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    state == rplb_pkg::S_SW_WR && w == LAST_IDX |=> cur != $past(cur))
    else $error("bank did not swap after rebuild");

endmodule
